/* hw/rtl/slt_pkg.sv */
// Shared types, character codes and token-kind codes for the shell line tokenizer.
package slt_pkg;

  localparam int TOK_W = 12;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [TOK_W-1:0] tok_start;
    logic [TOK_W-1:0] tok_end;
    logic             no_token;
    logic             line_done;
    logic             overflow;
  } out_t;

  // Up to two results per character, r0 first.
  typedef struct packed {
    logic v0;
    logic v1;
    out_t r0;
    out_t r1;
  } step_res_t;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_WORD  = 3'd1;
  localparam logic [2:0] KIND_DIGIT = 3'd2;
  localparam logic [2:0] KIND_AMP   = 3'd3;
  localparam logic [2:0] KIND_PIPE  = 3'd4;
  localparam logic [2:0] KIND_LT    = 3'd5;
  localparam logic [2:0] KIND_GT    = 3'd6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  // Output queue: two results may enter per cycle, one leaves.
  localparam int Q_DEPTH = 4;
  localparam int QIDX_W  = 2;
  localparam int QCNT_W  = 3;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  function automatic logic ends_word(input logic [7:0] c);
    return (c == CH_BANG) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_SEMI) || (c == CH_AMP) || (c == CH_PIPE) || (c == CH_LT) ||
           (c == CH_GT) || (c == CH_SPACE) || (c == CH_BSLASH);
  endfunction

endpackage

/* hw/rtl/slt_step.sv */
// Per-character tokenizer rule: line state registers and the result logic for one character.
module slt_step #(
  parameter int LINE_LEN = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  slt_pkg::in_t      item,
  output slt_pkg::step_res_t res
);

  localparam int POS_W = $clog2(LINE_LEN + 1);
  localparam int OFF_W = $clog2(LINE_LEN);

  logic [POS_W-1:0] position, position_next;
  logic [2:0]       kind, kind_next;
  logic [OFF_W-1:0] pstart, pstart_next;
  logic             prev_amp, prev_amp_next;
  logic             ovf, ovf_next;

  logic [2:0]       kind_eff;
  logic             closing;
  logic             full;
  logic             taken;
  logic             pair;
  logic             flush;
  logic             single;
  logic [OFF_W-1:0] p;
  logic [OFF_W-1:0] close_end;
  slt_pkg::out_t    flush_res;
  slt_pkg::out_t    single_res;

  assign kind_eff  = (kind > slt_pkg::KIND_GT) ? slt_pkg::KIND_NONE : kind;
  assign closing   = item.line_end || (item.ch == slt_pkg::CH_NUL);
  assign full      = (position >= POS_W'(LINE_LEN));
  assign p         = position[OFF_W-1:0];
  assign close_end = (position != '0) ? OFF_W'(position - POS_W'(1)) : '0;

  always_comb begin
    taken = 1'b0;
    pair  = 1'b0;
    case (kind_eff)
      slt_pkg::KIND_WORD:  taken = !slt_pkg::ends_word(item.ch);
      slt_pkg::KIND_DIGIT: taken = slt_pkg::is_digit(item.ch);
      slt_pkg::KIND_AMP:   pair  = (item.ch == slt_pkg::CH_AMP);
      slt_pkg::KIND_PIPE:  pair  = (item.ch == slt_pkg::CH_PIPE);
      slt_pkg::KIND_LT:    pair  = (item.ch == slt_pkg::CH_LT) || (item.ch == slt_pkg::CH_GT) ||
                                   (item.ch == slt_pkg::CH_AMP);
      slt_pkg::KIND_GT:    pair  = (item.ch == slt_pkg::CH_GT) || (item.ch == slt_pkg::CH_AMP);
      default: begin
        taken = 1'b0;
        pair  = 1'b0;
      end
    endcase
  end

  assign flush  = (kind_eff != slt_pkg::KIND_NONE) && !taken;
  // single-character tokens only when the character was not absorbed
  assign single = !taken && !(flush && pair) &&
                  ((item.ch == slt_pkg::CH_SEMI) || (item.ch == slt_pkg::CH_LPAREN) ||
                   (item.ch == slt_pkg::CH_RPAREN) || (item.ch == slt_pkg::CH_BANG) ||
                   ((item.ch == slt_pkg::CH_DASH) && prev_amp));

  always_comb begin
    flush_res.tok_start  = slt_pkg::TOK_W'(pstart);
    flush_res.tok_end    = pair ? slt_pkg::TOK_W'(p) : slt_pkg::TOK_W'(p - OFF_W'(1));
    flush_res.no_token   = 1'b0;
    flush_res.line_done  = 1'b0;
    flush_res.overflow   = ovf;
    single_res.tok_start = slt_pkg::TOK_W'(p);
    single_res.tok_end   = slt_pkg::TOK_W'(p);
    single_res.no_token  = 1'b0;
    single_res.line_done = 1'b0;
    single_res.overflow  = ovf;
  end

  always_comb begin
    position_next = position;
    kind_next     = kind;
    pstart_next   = pstart;
    prev_amp_next = prev_amp;
    ovf_next      = ovf;
    res           = '0;
    if (closing) begin
      res.v0           = 1'b1;
      res.r0.line_done = 1'b1;
      res.r0.overflow  = ovf;
      if (kind_eff != slt_pkg::KIND_NONE) begin
        res.r0.tok_start = slt_pkg::TOK_W'(pstart);
        res.r0.tok_end   = slt_pkg::TOK_W'(close_end);
      end else begin
        res.r0.no_token = 1'b1;
      end
      position_next = '0;
      kind_next     = slt_pkg::KIND_NONE;
      pstart_next   = '0;
      prev_amp_next = 1'b0;
      ovf_next      = 1'b0;
    end else if (full) begin
      ovf_next = 1'b1;
    end else begin
      if (flush) begin
        res.v0 = 1'b1;
        res.r0 = flush_res;
        res.v1 = single;
        res.r1 = single_res;
      end else begin
        res.v0 = single;
        res.r0 = single_res;
      end
      kind_next = flush ? slt_pkg::KIND_NONE : kind_eff;
      if (!taken && !(flush && pair) && !single && (item.ch != slt_pkg::CH_SPACE)) begin
        pstart_next = p;
        if (item.ch == slt_pkg::CH_AMP)        kind_next = slt_pkg::KIND_AMP;
        else if (item.ch == slt_pkg::CH_PIPE)  kind_next = slt_pkg::KIND_PIPE;
        else if (item.ch == slt_pkg::CH_LT)    kind_next = slt_pkg::KIND_LT;
        else if (item.ch == slt_pkg::CH_GT)    kind_next = slt_pkg::KIND_GT;
        else if (slt_pkg::is_digit(item.ch))   kind_next = slt_pkg::KIND_DIGIT;
        else                                   kind_next = slt_pkg::KIND_WORD;
      end
      prev_amp_next = (item.ch == slt_pkg::CH_AMP);
      position_next = position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      kind     <= slt_pkg::KIND_NONE;
      pstart   <= '0;
      prev_amp <= 1'b0;
      ovf      <= 1'b0;
    end else if (go) begin
      position <= position_next;
      kind     <= kind_next;
      pstart   <= pstart_next;
      prev_amp <= prev_amp_next;
      ovf      <= ovf_next;
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (go && closing) |=> (position == '0) && (kind == slt_pkg::KIND_NONE) && !ovf)
    else $error("line state not cleared after line close");

  a_close_single: assert property (@(posedge clk) disable iff (rst)
    (res.v0 && res.r0.line_done) |-> !res.v1)
    else $error("line close produced a second result");

  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    (go && !closing && full) |=> (position == $past(position)) && ovf)
    else $error("dropped character moved the position");

endmodule

/* hw/rtl/slt_outq.sv */
// Four-entry result queue: takes up to two results per cycle, delivers one.
module slt_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  slt_pkg::step_res_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output slt_pkg::out_t      out_data
);

  slt_pkg::out_t             mem [slt_pkg::Q_DEPTH];
  logic [slt_pkg::QIDX_W-1:0] head, tail;
  logic [slt_pkg::QCNT_W-1:0] count;
  logic [1:0]                n_push;
  logic                      pop;

  assign n_push    = wr ? ({1'b0, push.v0} + {1'b0, push.v1}) : 2'd0;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[head];
  assign room      = (count <= slt_pkg::QCNT_W'(slt_pkg::Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr && push.v0) mem[tail] <= push.r0;
    if (wr && push.v1) mem[tail + slt_pkg::QIDX_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + slt_pkg::QIDX_W'(n_push);
      head  <= head + slt_pkg::QIDX_W'(pop);
      count <= count + slt_pkg::QCNT_W'(n_push) - slt_pkg::QCNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= slt_pkg::QCNT_W'(slt_pkg::Q_DEPTH))
    else $error("result queue count out of range");

  a_wr_room: assert property (@(posedge clk) disable iff (rst)
    wr |-> room)
    else $error("results written without room for two");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (wr && push.v1) |-> push.v0)
    else $error("second result without a first");

endmodule

/* hw/rtl/shell_line_tokenizer_unit.sv */
// Shell line tokenizer top level: input register, tokenizer step and result queue.
//
// Usage: characters of a command line arrive on the in channel (in_valid,
// in_ready, in_data), one per transfer; a transfer with line_end set, or a zero
// byte, closes the line. Each token comes back on the out channel (out_valid,
// out_ready, out_data) as its first and last offset in the line; the line
// close always yields one result with line_done set, with no_token set when
// no token was open. Characters at offset LINE_LEN or beyond are dropped and
// the overflow flag is raised on the remaining results of that line.
// A result passes through the input register and then into the result queue
// before it can transfer on the out channel.
// Throughput: one character per cycle while out_ready stays high and each character yields at most one
// result; a character that closes a token and forms a one-character token
// gives two results, which leave through the single output port one at a time.
// The four-entry result queue sets this: a character leaves the input
// register only when two queue entries are free.
// Reset clears all line state and the queue. When out_ready is low, results
// collect in the queue and in_ready drops once the input register holds a
// character and fewer than two queue entries are free; no result is lost.
module shell_line_tokenizer_unit #(
  parameter int LINE_LEN = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  slt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output slt_pkg::out_t out_data
);

  logic               in_reg_valid;
  slt_pkg::in_t       in_reg;
  logic               go;
  logic               room;
  slt_pkg::step_res_t res;

  assign go       = in_reg_valid && room;
  assign in_ready = !in_reg_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_reg <= in_data;
  end

  slt_step #(
    .LINE_LEN(LINE_LEN)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (in_reg),
    .res  (res)
  );

  slt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr        (go),
    .push      (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
